// ===== rtl/core/lru_replacement_tracker_macros.svh =====
// Assertion macros for the LRU replacement tracker.
// Used by the top level only.
`ifndef LRU_REPLACEMENT_TRACKER_MACROS_SVH
`define LRU_REPLACEMENT_TRACKER_MACROS_SVH
`define LRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru tracker check failed");
`define LRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru tracker check failed");
`endif

// ===== rtl/core/lrt_pkg.sv =====
// Package for the LRU replacement tracker: sizes, action and status codes, FSM states.
// No dependencies.
`default_nettype none
package lrt_pkg;
   localparam int LRT_ENTRIES = 16;
   localparam int KEY_W = 32;
   typedef enum logic [1:0] {
      ACT_TOUCH  = 2'd0,
      ACT_VICTIM = 2'd1,
      ACT_ERASE  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;
   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2,
      ST_RSVD   = 2'd3
   } status_type;
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_APPEND,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/core/lru_replacement_tracker.sv =====
// LRU replacement tracker: keys in recency order in one RAM, slot 0 least recent.
// Flow from accept to rsp_valid: scan to the match one slot per cycle (pipelined read),
// shift later slots down one per cycle, then append on a touch, then respond.
// One transaction at a time; the next is accepted the cycle after the response is taken.
// Reset (synchronous, active high) empties the set; the RAM needs no clearing.
// Depends on lrt_pkg, lrt_ram and lru_replacement_tracker_macros.svh.
`default_nettype none
`include "lru_replacement_tracker_macros.svh"
module lru_replacement_tracker #(
   parameter int ENTRIES = lrt_pkg::LRT_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_action,
   input  wire logic [lrt_pkg::KEY_W-1:0] req_key,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [lrt_pkg::KEY_W-1:0]     rsp_victim_key,
   output logic [$clog2(ENTRIES+1)-1:0]  rsp_count
);
   import lrt_pkg::*;
   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES+1);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          found_ff, found_in;
   logic [1:0]    act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [1:0]    st_ff, st_in;
   logic [KEY_W-1:0] vic_ff, vic_in;
   logic          ovalid_ff, ovalid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [KEY_W-1:0] wr_data, rd_data;
   logic [CW-1:0] rd_slot;

   lrt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp_valid = ovalid_ff;
   assign rsp_status = st_ff;
   assign rsp_victim_key = vic_ff;
   assign rsp_count = count_ff;

   // rd_slot: slot whose data appears on rd_data this cycle (issued last cycle)
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      found_in = found_ff;
      act_in = act_ff;
      key_in = key_ff;
      st_in = st_ff;
      vic_in = vic_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = key_ff;
      rd_addr = idx_ff[AW-1:0];
      rd_slot = idx_ff - CW'(1);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               act_in = req_action;
               key_in = req_key;
               st_in = ST_DONE;
               vic_in = '0;
               found_in = 1'b0;
               idx_in = '0;
               unique case (action_type'(req_action))
                  ACT_TOUCH, ACT_ERASE: begin
                     if (count_ff == '0) begin
                        state_in = (req_action == ACT_TOUCH) ? S_APPEND : S_RESP;
                        if (req_action == ACT_ERASE) st_in = ST_ABSENT;
                     end else begin
                        idx_in = CW'(1);
                        rd_addr = '0;
                        state_in = S_SCAN;
                     end
                  end
                  ACT_VICTIM: begin
                     if (count_ff == '0) begin
                        st_in = ST_ABSENT;
                        state_in = S_RESP;
                     end else begin
                        idx_in = CW'(1);
                        rd_addr = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            // compare returning data, keep issuing reads
            if (act_ff == ACT_VICTIM) begin
               vic_in = rd_data;
               pos_in = '0;
               found_in = 1'b1;
               state_in = S_SHIFT;
               idx_in = CW'(1);
               rd_addr = '0;
               if (count_ff > CW'(1)) rd_addr = AW'(1);
               if (count_ff > CW'(1)) idx_in = CW'(2);
            end else if (rd_data == key_ff) begin
               pos_in = rd_slot;
               found_in = 1'b1;
               state_in = S_SHIFT;
               rd_addr = idx_ff[AW-1:0];
               idx_in = idx_ff + CW'(1);
               if (act_ff == ACT_TOUCH && idx_ff >= count_ff) begin
                  state_in = S_APPEND;
                  count_in = count_ff - CW'(1);
               end else if (idx_ff >= count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_RESP;
               end
            end else if (idx_ff >= count_ff) begin
               if (act_ff == ACT_ERASE) begin
                  st_in = ST_ABSENT;
                  state_in = S_RESP;
               end else if (count_ff >= CW'(ENTRIES)) begin
                  st_in = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  state_in = S_APPEND;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
            if (act_ff == ACT_VICTIM && count_ff == CW'(1)) begin
               count_in = '0;
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            // rd_data holds slot rd_slot; write it one lower
            wr_en = 1'b1;
            wr_addr = AW'(rd_slot - CW'(1));
            wr_data = rd_data;
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = (act_ff == ACT_TOUCH) ? S_APPEND : S_RESP;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_APPEND: begin
            wr_en = 1'b1;
            wr_addr = count_ff[AW-1:0];
            wr_data = key_ff;
            count_in = count_ff + CW'(1);
            state_in = S_RESP;
         end
         S_RESP: begin
            ovalid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      found_ff <= found_in;
      act_ff <= act_in;
      key_ff <= key_in;
      st_ff <= st_in;
      vic_ff <= vic_in;
   end

   `LRT_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CW'(ENTRIES))
   `LRT_ASSERT_NEXT(a_full_keeps, clock, reset,
      ovalid_ff && rsp_ready && st_ff == ST_FULL, count_ff == $past(count_ff))
   `LRT_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req_ready)
endmodule
`default_nettype wire

// ===== rtl/core/lrt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module lrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== tb/lru_replacement_tracker_tb.sv =====
// Self-checking testbench for lru_replacement_tracker: directed table, then random
// transactions checked against an in-bench recency-list model, under varied idling and stalls.
// Depends on lrt_pkg and the lru_replacement_tracker RTL.
`default_nettype none
module lru_replacement_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lrt_pkg::*;

   localparam int N_ENT = LRT_ENTRIES;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] victim_key;
      logic [4:0]  count;
   } lru_result_t;

   typedef struct {
      action_type  act;
      logic [31:0] key;
      bit          known;
      lru_result_t res;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_TOUCH;
   logic [31:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_victim_key;
   logic [4:0]  rsp_count;

   lru_replacement_tracker uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_victim_key(rsp_victim_key),
      .rsp_count(rsp_count)
   );

   always #5 clock = ~clock;

   logic [31:0] recency_keys[N_ENT];
   int          keys_held = 0;
   lru_result_t pending_results[$];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_off_cycles = 0;
   longint      cycle_count = 0;

   function automatic int find_key(logic [31:0] k);
      for (int i = 0; i < keys_held; i++)
         if (recency_keys[i] == k) return i;
      return -1;
   endfunction

   function automatic void remove_at(int pos);
      for (int i = pos; i + 1 < keys_held; i++)
         recency_keys[i] = recency_keys[i + 1];
      keys_held--;
   endfunction

   function automatic lru_result_t apply_lru(action_type act, logic [31:0] k);
      lru_result_t r;
      int pos;
      r = '0;
      r.status = ST_DONE;
      case (act)
         ACT_TOUCH: begin
            pos = find_key(k);
            if (pos >= 0) begin
               remove_at(pos);
               recency_keys[keys_held] = k;
               keys_held++;
            end else if (keys_held >= N_ENT) begin
               r.status = ST_FULL;
            end else begin
               recency_keys[keys_held] = k;
               keys_held++;
            end
         end
         ACT_VICTIM: begin
            if (keys_held == 0) begin
               r.status = ST_ABSENT;
            end else begin
               r.victim_key = recency_keys[0];
               remove_at(0);
            end
         end
         ACT_ERASE: begin
            pos = find_key(k);
            if (pos >= 0) remove_at(pos);
            else r.status = ST_ABSENT;
         end
         default: ;
      endcase
      r.count = 5'(keys_held);
      return r;
   endfunction

   // Result checker and receiver stall
   always @(posedge clock) begin
      lru_result_t exp_r;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction: status %0d victim_key %h count %0d",
                   rsp_status, rsp_victim_key, rsp_count);
            fail_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d actual %0d", exp_r.status, rsp_status);
               fail_count++;
            end
            if (rsp_victim_key !== exp_r.victim_key) begin
               $error("victim_key: expected %h actual %h", exp_r.victim_key, rsp_victim_key);
               fail_count++;
            end
            if (rsp_count !== exp_r.count) begin
               $error("count: expected %0d actual %0d", exp_r.count, rsp_count);
               fail_count++;
            end
         end
      end
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lru_replacement_tracker regression: fail");
         $finish;
      end
   end

   task automatic send_item(action_type act, logic [31:0] k, bit known, lru_result_t res);
      lru_result_t pred;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_key <= k;
      do @(posedge clock); while (!req_ready);
      pred = apply_lru(act, k);
      if (known && pred !== res) begin
         $error("table row %0d/%h: expected %h predicted %h", act, k, res, pred);
         fail_count++;
      end
      pending_results.push_back(pred);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic lru_result_t mk(status_type s, logic [31:0] v, int c);
      lru_result_t r;
      r.status = s;
      r.victim_key = v;
      r.count = 5'(c);
      return r;
   endfunction

   function automatic logic [31:0] rand_key(int pool);
      if ($urandom_range(9) == 0) return $urandom();
      return 32'($urandom_range(pool - 1)) ^ 32'hA5C3_0000;
   endfunction

   initial begin
      stim_row_t rows[$];
      action_type act;
      int phase_idle[4] = '{0, 61, 0, 18};
      int phase_stall[4] = '{0, 0, 61, 18};
      int w;

      rows.push_back('{ACT_VICTIM, 32'h0, 1'b1, mk(ST_ABSENT, 0, 0)});
      rows.push_back('{ACT_ERASE, 32'h1234, 1'b1, mk(ST_ABSENT, 0, 0)});
      rows.push_back('{ACT_NONE, 32'hFFFF_FFFF, 1'b1, mk(ST_DONE, 0, 0)});
      rows.push_back('{ACT_TOUCH, 32'h0, 1'b1, mk(ST_DONE, 0, 1)});
      rows.push_back('{ACT_TOUCH, 32'hFFFF_FFFF, 1'b1, mk(ST_DONE, 0, 2)});
      rows.push_back('{ACT_TOUCH, 32'h0, 1'b1, mk(ST_DONE, 0, 2)});
      rows.push_back('{ACT_VICTIM, 32'h0, 1'b1, mk(ST_DONE, 32'hFFFF_FFFF, 1)});
      for (int i = 1; i < N_ENT; i++)
         rows.push_back('{ACT_TOUCH, 32'h5555_0000 + i, 1'b0, '0});
      rows.push_back('{ACT_TOUCH, 32'hAAAA_AAAA, 1'b1, mk(ST_FULL, 0, 16)});
      rows.push_back('{ACT_TOUCH, 32'h0, 1'b0, '0});
      rows.push_back('{ACT_ERASE, 32'h5555_0007, 1'b0, '0});
      rows.push_back('{ACT_VICTIM, 32'h0, 1'b0, '0});
      rows.push_back('{ACT_NONE, 32'h0, 1'b0, '0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_item(rows[i].act, rows[i].key, rows[i].known, rows[i].res);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct = phase_idle[ph % 4];
         recv_stall_pct = phase_stall[ph % 4];
         if (ph == 4) hold_off_cycles = 300;
         for (int n = 0; n < 100; n++) begin
            w = $urandom_range(99);
            if (w < 50) act = ACT_TOUCH;
            else if (w < 72) act = ACT_VICTIM;
            else if (w < 96) act = ACT_ERASE;
            else act = ACT_NONE;
            send_item(act, rand_key((ph % 2) ? 24 : 12), 1'b0, '0);
         end
         if (ph == 2) drain();
      end

      send_idle_pct = 0;
      drain();
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("lru_replacement_tracker regression: pass");
      else
         $display("lru_replacement_tracker regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
